// ----- design/gravity_by_altitude_interpolator_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the gravity interpolator
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRAVITY_BY_ALTITUDE_INTERPOLATOR_TOP_MACROS_SVH
`define GRAVITY_BY_ALTITUDE_INTERPOLATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GBAI_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gbai: property violated");
`define GBAI_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("gbai: forbidden condition");
`else
`define GBAI_ASSERT(lbl, prop)
`define GBAI_NEVER(lbl, cond)
`endif
`endif

// ----- design/gbai_pkg.sv -----
// ----------------------------------------------------------------------------
// gbai_pkg
// Types, table constants and segment lookups of the gravity interpolator.
// ----------------------------------------------------------------------------
package gbai_pkg;

	localparam int TABLE_POINTS = 14;
	localparam int ALT_W        = 20;
	localparam int MASS_W       = 16;
	localparam int ACC_W        = 21;
	localparam int FORCE_W      = 32;
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = 2;
	localparam int FIFO_DEPTH   = 2;
	localparam int SEG_W        = (TABLE_POINTS > 2) ? $clog2(TABLE_POINTS - 1) : 1;
	// largest step between neighboring accelerations is 1049
	localparam int DA_W         = 11;
	localparam int NUM_W        = DA_W + ALT_W;

	typedef logic        [ALT_W-1:0]   alt_t;
	typedef logic        [MASS_W-1:0]  mass_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [FORCE_W-1:0] force_t;
	typedef logic        [SEG_W-1:0]   seg_t;
	typedef logic        [DA_W-1:0]    da_t;
	typedef logic        [NUM_W-1:0]   num_t;

	localparam logic [ADDR_W-1:0] REG_FALLBACK_ADDR = 2'd0;
	localparam acc_t FALLBACK_RESET = -21'sd595067;

	localparam alt_t ALT_TAB [TABLE_POINTS] = '{
		20'd0, 20'd16000, 20'd32000, 20'd48000, 20'd64000, 20'd80000, 20'd96000,
		20'd112000, 20'd128000, 20'd144000, 20'd160000, 20'd240000, 20'd320000,
		20'd400000
	};

	localparam acc_t ACC_TAB [TABLE_POINTS] = '{
		-21'sd642712, -21'sd642515, -21'sd642318, -21'sd642056, -21'sd641860,
		-21'sd641663, -21'sd641466, -21'sd641270, -21'sd641073, -21'sd640877,
		-21'sd640680, -21'sd639697, -21'sd638648, -21'sd637665
	};

	localparam alt_t SPAN_A = 20'd16000;
	localparam alt_t SPAN_B = 20'd80000;

	localparam alt_t SPAN_TAB [TABLE_POINTS-1] = '{
		SPAN_A, SPAN_A, SPAN_A, SPAN_A, SPAN_A, SPAN_A, SPAN_A, SPAN_A, SPAN_A,
		SPAN_A, SPAN_B, SPAN_B, SPAN_B
	};

	// floor(2^NUM_W / span): quotient estimate is exact or one low
	localparam longint unsigned RECIP_ONE   = 64'd1 << NUM_W;
	localparam longint unsigned RECIP_A_VAL = RECIP_ONE / SPAN_A;
	localparam longint unsigned RECIP_B_VAL = RECIP_ONE / SPAN_B;
	localparam int RECIP_W = $clog2(RECIP_A_VAL + 1);

	typedef logic [RECIP_W-1:0] recip_t;

	localparam recip_t RECIP_A = RECIP_W'(RECIP_A_VAL);
	localparam recip_t RECIP_B = RECIP_W'(RECIP_B_VAL);

	localparam recip_t RECIP_TAB [TABLE_POINTS-1] = '{
		RECIP_A, RECIP_A, RECIP_A, RECIP_A, RECIP_A, RECIP_A, RECIP_A, RECIP_A,
		RECIP_A, RECIP_A, RECIP_B, RECIP_B, RECIP_B
	};

	typedef struct packed {
		logic  oor;
		seg_t  seg;
		alt_t  delta;
		mass_t mass;
	} item_t;

	function automatic logic signed [ACC_W:0] seg_diff(input seg_t seg);
		logic signed [ACC_W:0] d;
		d = '0;
		if (int'(seg) < TABLE_POINTS - 1) begin
			d = (ACC_W+1)'(ACC_TAB[int'(seg) + 1]) - (ACC_W+1)'(ACC_TAB[seg]);
		end
		return d;
	endfunction

	function automatic da_t seg_da(input seg_t seg);
		logic signed [ACC_W:0] d;
		d = seg_diff(seg);
		if (d < 0) begin
			d = -d;
		end
		return DA_W'(d);
	endfunction

	function automatic logic seg_neg(input seg_t seg);
		return seg_diff(seg) < 0;
	endfunction

	function automatic alt_t seg_span(input seg_t seg);
		alt_t s;
		s = '0;
		if (int'(seg) < TABLE_POINTS - 1) begin
			s = SPAN_TAB[seg];
		end
		return s;
	endfunction

	function automatic recip_t seg_recip(input seg_t seg);
		recip_t r;
		r = '0;
		if (int'(seg) < TABLE_POINTS - 1) begin
			r = RECIP_TAB[seg];
		end
		return r;
	endfunction

	function automatic acc_t acc_min();
		acc_t m;
		m = ACC_TAB[0];
		for (int i = 1; i < TABLE_POINTS; i++) begin
			if (ACC_TAB[i] < m) begin
				m = ACC_TAB[i];
			end
		end
		return m;
	endfunction

	function automatic acc_t acc_max();
		acc_t m;
		m = ACC_TAB[0];
		for (int i = 1; i < TABLE_POINTS; i++) begin
			if (ACC_TAB[i] > m) begin
				m = ACC_TAB[i];
			end
		end
		return m;
	endfunction

	function automatic da_t da_max();
		da_t m;
		m = '0;
		for (int i = 0; i < TABLE_POINTS - 1; i++) begin
			if (seg_da(SEG_W'(i)) > m) begin
				m = seg_da(SEG_W'(i));
			end
		end
		return m;
	endfunction

	localparam acc_t ACC_MIN = acc_min();
	localparam acc_t ACC_MAX = acc_max();
	localparam da_t  DA_MAX  = da_max();

endpackage

// ----- design/gbai_front.sv -----
// ----------------------------------------------------------------------------
// gbai_front
// Takes an altitude/mass beat, finds its table segment and offset.
// ----------------------------------------------------------------------------
module gbai_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  gbai_pkg::alt_t  altitude,
	input  gbai_pkg::mass_t mass,
	input  logic            full,
	output logic            push,
	output gbai_pkg::item_t item
);
	import gbai_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t cls;
	logic  accept;

	always_comb begin
		cls.oor  = altitude > ALT_TAB[TABLE_POINTS-1];
		cls.seg  = '0;
		cls.mass = mass;
		for (int i = 1; i < TABLE_POINTS - 1; i++) begin
			if (altitude >= ALT_TAB[i]) begin
				cls.seg = SEG_W'(i);
			end
		end
		cls.delta = altitude - ALT_TAB[cls.seg];
	end

	assign push   = valid_s1 && !full;
	assign busy   = valid_s1 && full;
	assign accept = start && !busy;
	assign item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cls;
		end
	end

endmodule

// ----- design/gbai_fifo.sv -----
// ----------------------------------------------------------------------------
// gbai_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`include "gravity_by_altitude_interpolator_top_macros.svh"

module gbai_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gbai_pkg::item_t wr_item,
	input  logic            pop,
	output gbai_pkg::item_t rd_item,
	output logic            full,
	output logic            empty
);
	import gbai_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	item_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full    = count_q == CNT_W'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign rd_item = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	`GBAI_NEVER(a_no_overflow, push && full)
	`GBAI_NEVER(a_no_underflow, pop && empty)
	`GBAI_ASSERT(a_push_fills, push && !pop |=> !empty)

endmodule

// ----- design/gbai_back.sv -----
// ----------------------------------------------------------------------------
// gbai_back
// Interpolation pipeline: multiply, reciprocal divide, correct, scale by mass.
// ----------------------------------------------------------------------------
`include "gravity_by_altitude_interpolator_top_macros.svh"

module gbai_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop,
	input  gbai_pkg::item_t  item,
	input  gbai_pkg::acc_t   fallback,
	output logic             done,
	output gbai_pkg::acc_t   gravity_accel,
	output gbai_pkg::force_t gravity_force,
	output logic             out_of_range
);
	import gbai_pkg::*;

	localparam int PROD_W = NUM_W + RECIP_W;
	localparam int LIM_W  = NUM_W + 1;
	localparam int FP_W   = MASS_W + 1 + ACC_W;

	logic   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	num_t   num_s1;
	acc_t   a0_s1;
	alt_t   span_s1;
	recip_t recip_s1;
	logic   neg_s1, oor_s1;
	mass_t  mass_s1;

	da_t    q0_s2;
	num_t   num_s2;
	acc_t   a0_s2;
	alt_t   span_s2;
	logic   neg_s2, oor_s2;
	mass_t  mass_s2;

	logic [LIM_W-1:0] lim_s3;
	da_t    q0_s3;
	num_t   num_s3;
	acc_t   a0_s3;
	logic   neg_s3, oor_s3;
	mass_t  mass_s3;

	da_t    q_s4;
	acc_t   a0_s4;
	logic   neg_s4, oor_s4;
	mass_t  mass_s4;

	acc_t   accel_s5;
	logic   oor_s5;
	mass_t  mass_s5;

	acc_t   accel_s6;
	force_t force_s6;
	logic   oor_s6;

	logic [PROD_W-1:0]     prod;
	logic signed [ACC_W:0] q_ext;
	logic signed [ACC_W:0] sum;
	logic signed [FP_W-1:0] fprod;

	assign prod  = PROD_W'(num_s1) * PROD_W'(recip_s1);
	assign q_ext = neg_s4 ? -$signed((ACC_W+1)'(q_s4)) : $signed((ACC_W+1)'(q_s4));
	assign sum   = (ACC_W+1)'(a0_s4) + q_ext;
	assign fprod = $signed({1'b0, mass_s5}) * accel_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		num_s1   <= NUM_W'(seg_da(item.seg)) * NUM_W'(item.delta);
		a0_s1    <= ACC_TAB[item.seg];
		span_s1  <= seg_span(item.seg);
		recip_s1 <= seg_recip(item.seg);
		neg_s1   <= seg_neg(item.seg);
		oor_s1   <= item.oor;
		mass_s1  <= item.mass;

		q0_s2   <= DA_W'(prod >> NUM_W);
		num_s2  <= num_s1;
		a0_s2   <= a0_s1;
		span_s2 <= span_s1;
		neg_s2  <= neg_s1;
		oor_s2  <= oor_s1;
		mass_s2 <= mass_s1;

		lim_s3  <= (LIM_W'(q0_s2) + LIM_W'(1)) * LIM_W'(span_s2);
		q0_s3   <= q0_s2;
		num_s3  <= num_s2;
		a0_s3   <= a0_s2;
		neg_s3  <= neg_s2;
		oor_s3  <= oor_s2;
		mass_s3 <= mass_s2;

		q_s4    <= q0_s3 + DA_W'(LIM_W'(num_s3) >= lim_s3);
		a0_s4   <= a0_s3;
		neg_s4  <= neg_s3;
		oor_s4  <= oor_s3;
		mass_s4 <= mass_s3;

		accel_s5 <= oor_s4 ? fallback : ACC_W'(sum);
		oor_s5   <= oor_s4;
		mass_s5  <= mass_s4;

		accel_s6 <= accel_s5;
		force_s6 <= FORCE_W'(fprod >>> 8);
		oor_s6   <= oor_s5;
	end

	assign done          = valid_s6;
	assign gravity_accel = accel_s6;
	assign gravity_force = force_s6;
	assign out_of_range  = oor_s6;

	`GBAI_ASSERT(a_latency, pop |-> ##6 valid_s6)
	`GBAI_NEVER(a_quot_bound, valid_s2 && !oor_s2 && (q0_s2 > DA_MAX))
	`GBAI_NEVER(a_accel_range, valid_s6 && !oor_s6 && (accel_s6 < ACC_MIN || accel_s6 > ACC_MAX))

endmodule

// ----- design/gravity_by_altitude_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// gravity_by_altitude_interpolator_top
// Piecewise-linear gravity lookup by altitude, scaled by mass to a force.
// ----------------------------------------------------------------------------
// Use:
//   Command channel: drive altitude (Q16.4 m) and mass (Q8.8 kg) with start;
//   the beat is taken on a clock edge where start is high and busy is low.
//   Result channel: done is high for one cycle with gravity_accel (Q4.16),
//   gravity_force (Q15.16) and out_of_range; results come back in order.
//   A beat passes the front register, the queue and then the back stages.
//   Throughput: one beat per cycle; the front register, the two-entry queue
//   and the six-stage back pipeline all advance every cycle, and busy only
//   rises if the queue is full.
//   The receiver cannot stall: each result is presented once and lost if
//   not captured.
//   APB port: register 0 (byte address 0) holds the fallback acceleration
//   used above 25000 m. Write it only while no beat is in flight.
//   Reset: arst_n clears the pipeline and queue and loads the fallback with
//   its default of -9.08 m/s^2; no result is pending after reset.
// ----------------------------------------------------------------------------
module gravity_by_altitude_interpolator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  gbai_pkg::alt_t                 altitude,
	input  gbai_pkg::mass_t                mass,
	output logic                           done,
	output gbai_pkg::acc_t                 gravity_accel,
	output gbai_pkg::force_t               gravity_force,
	output logic                           out_of_range,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gbai_pkg::ADDR_W-1:0]    paddr,
	input  logic [gbai_pkg::DATA_W-1:0]    pwdata,
	output logic [gbai_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);
	import gbai_pkg::*;

	acc_t  fallback_q;
	item_t front_item;
	item_t back_item;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = (paddr == REG_FALLBACK_ADDR) ?
		{{(DATA_W-ACC_W){fallback_q[ACC_W-1]}}, fallback_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_q <= FALLBACK_RESET;
		end else if (wr_en) begin
			fallback_q <= acc_t'(pwdata[ACC_W-1:0]);
		end
	end

	assign pop = !empty;

	gbai_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.altitude (altitude),
		.mass     (mass),
		.full     (full),
		.push     (push),
		.item     (front_item)
	);

	gbai_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.pop     (pop),
		.rd_item (back_item),
		.full    (full),
		.empty   (empty)
	);

	gbai_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop           (pop),
		.item          (back_item),
		.fallback      (fallback_q),
		.done          (done),
		.gravity_accel (gravity_accel),
		.gravity_force (gravity_force),
		.out_of_range  (out_of_range)
	);

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gravity interpolator. Beats are driven on the
// command channel; each result is given in the directed table or predicted
// from internal copies of the tables and fallback register, and checked in
// order as it arrives. A short directed table comes first, then random
// phases under several fallback settings and sender idle rates.
// ----------------------------------------------------------------------------
module tb;

	import gbai_pkg::*;

	typedef struct packed {
		logic signed [20:0] acc;
		logic signed [31:0] frc;
		logic               oor;
	} grav_res_t;

	typedef struct packed {
		logic [19:0] alt;
		logic [15:0] m;
		logic        typed;
		grav_res_t   want;
	} dir_row_t;

	localparam int N_PTS       = 14;
	localparam int N_DIR       = 18;
	localparam int N_PHASE     = 6;
	localparam int PHASE_BEATS = 200;
	localparam int DRAIN_WAIT  = 12;
	localparam int STALL_LIMIT = 2000;

	localparam longint ALT_PTS [N_PTS] = '{
		0, 16000, 32000, 48000, 64000, 80000, 96000,
		112000, 128000, 144000, 160000, 240000, 320000, 400000
	};
	localparam longint ACC_PTS [N_PTS] = '{
		-642712, -642515, -642318, -642056, -641860, -641663, -641466,
		-641270, -641073, -640877, -640680, -639697, -638648, -637665
	};

	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{20'd0,      16'h0000, 1'b1, '{-21'sd642712, 32'sd0,       1'b0}},
		'{20'd0,      16'h0100, 1'b1, '{-21'sd642712, -32'sd642712, 1'b0}},
		'{20'd0,      16'hFFFF, 1'b0, '0},
		'{20'd1,      16'h0100, 1'b0, '0},
		'{20'd8000,   16'h0080, 1'b0, '0},
		'{20'd15999,  16'hFFFF, 1'b0, '0},
		'{20'd16000,  16'h0100, 1'b1, '{-21'sd642515, -32'sd642515, 1'b0}},
		'{20'd160000, 16'h0100, 1'b1, '{-21'sd640680, -32'sd640680, 1'b0}},
		'{20'd160001, 16'h1234, 1'b0, '0},
		'{20'd239999, 16'hFFFF, 1'b0, '0},
		'{20'd320000, 16'h0100, 1'b1, '{-21'sd638648, -32'sd638648, 1'b0}},
		'{20'd399999, 16'hFFFF, 1'b0, '0},
		'{20'd400000, 16'h0100, 1'b1, '{-21'sd637665, -32'sd637665, 1'b0}},
		'{20'd400001, 16'h0100, 1'b1, '{-21'sd595067, -32'sd595067, 1'b1}},
		'{20'd400001, 16'h0000, 1'b1, '{-21'sd595067, 32'sd0,       1'b1}},
		'{20'hFFFFF,  16'hFFFF, 1'b0, '0},
		'{20'hAAAAA,  16'h5555, 1'b0, '0},
		'{20'h55555,  16'hAAAA, 1'b0, '0}
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	alt_t               altitude;
	mass_t              mass;
	logic               done;
	acc_t               gravity_accel;
	force_t             gravity_force;
	logic               out_of_range;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	logic signed [20:0] fallback_q;
	grav_res_t          pending_results [$];
	int                 err_count;
	int                 quiet_cycles;

	gravity_by_altitude_interpolator_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.altitude      (altitude),
		.mass          (mass),
		.done          (done),
		.gravity_accel (gravity_accel),
		.gravity_force (gravity_force),
		.out_of_range  (out_of_range),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic grav_res_t gravity_expected(input logic [19:0] alt, input logic [15:0] m);
		grav_res_t r;
		longint    d;
		longint    a;
		longint    p;
		bit        found;
		d = longint'(alt);
		a = 0;
		found = 0;
		r.oor = 1'b0;
		if (d > ALT_PTS[N_PTS-1]) begin
			a = fallback_q;
			r.oor = 1'b1;
		end else begin
			for (int i = 0; i < N_PTS - 1; i++) begin
				if (!found && d <= ALT_PTS[i+1]) begin
					a = ACC_PTS[i] + (ACC_PTS[i+1] - ACC_PTS[i]) * (d - ALT_PTS[i]) /
						(ALT_PTS[i+1] - ALT_PTS[i]);
					found = 1;
				end
			end
		end
		p = longint'(m) * a;
		p = p >>> 8;
		r.acc = 21'(a);
		r.frc = 32'(p);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// called at a falling edge; returns at a falling edge with start still high
	task automatic send_beat(input logic [19:0] alt, input logic [15:0] m, input int idle_pct,
			input bit typed, input grav_res_t want);
		bit taken;
		taken = 0;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		altitude = alt;
		mass = m;
		while (!taken) begin
			@(posedge clk);
			if (!busy) begin
				taken = 1;
				pending_results.push_back(typed ? want : gravity_expected(alt, m));
			end
			@(negedge clk);
		end
	endtask

	task automatic apb_access(input bit wr, input logic [DATA_W-1:0] wdata,
			output logic [DATA_W-1:0] rdata);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = REG_FALLBACK_ADDR;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (wr) begin
			fallback_q = wdata[20:0];
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_fallback(input logic signed [20:0] val);
		logic [DATA_W-1:0] rd;
		apb_access(1'b1, DATA_W'(val), rd);
		apb_access(1'b0, '0, rd);
		if (rd[20:0] !== val) begin
			report_mismatch("fallback readback", longint'($signed(rd[20:0])), longint'(val));
		end
	endtask

	always @(posedge clk) begin
		grav_res_t w;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat, pending count", 0, 1);
			end else begin
				w = pending_results.pop_front();
				if (gravity_accel !== w.acc) begin
					report_mismatch("gravity_accel", longint'(gravity_accel), longint'(w.acc));
				end
				if (gravity_force !== w.frc) begin
					report_mismatch("gravity_force", longint'(gravity_force), longint'(w.frc));
				end
				if (out_of_range !== w.oor) begin
					report_mismatch("out_of_range", longint'(out_of_range), longint'(w.oor));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL gravity_by_altitude_interpolator_top");
			$finish;
		end
	end

	initial begin
		logic signed [20:0] fb_set [N_PHASE];
		logic [DATA_W-1:0]  rd;
		logic [19:0]        alt;
		logic [15:0]        m;
		longint             pt;
		int                 sel;
		int                 idle_pct;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		altitude = '0;
		mass = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fallback_q = FALLBACK_RESET;
		err_count = 0;
		quiet_cycles = 0;
		fb_set[0] = 21'sd1048575;
		fb_set[1] = -21'sd1048576;
		fb_set[2] = 21'sd0;
		fb_set[3] = 21'sd595067;
		fb_set[4] = 21'($urandom_range(2097151));
		fb_set[5] = -21'sd595067;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		apb_access(1'b0, '0, rd);
		if (rd[20:0] !== -21'sd595067) begin
			report_mismatch("fallback after reset", longint'($signed(rd[20:0])), -595067);
		end

		foreach (DIR_ROWS[i]) begin
			send_beat(DIR_ROWS[i].alt, DIR_ROWS[i].m, 38, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		end

		for (int ph = 0; ph < N_PHASE; ph++) begin
			start = 1'b0;
			wait (pending_results.size() == 0);
			repeat (DRAIN_WAIT) @(negedge clk);
			set_fallback(fb_set[ph]);
			idle_pct = (ph < 2) ? 38 : (ph < 4) ? 75 : 0;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				sel = $urandom_range(99);
				if (sel < 25) begin
					alt = 20'($urandom_range(1048575, 400001));
				end else if (sel < 35) begin
					alt = 20'(ALT_PTS[$urandom_range(N_PTS - 1)]);
				end else if (sel < 50) begin
					pt = ALT_PTS[$urandom_range(N_PTS - 1)] + longint'($urandom_range(6)) - 3;
					alt = (pt < 0) ? 20'd0 : 20'(pt);
				end else begin
					alt = 20'($urandom_range(400000));
				end
				sel = $urandom_range(99);
				m = (sel < 5) ? 16'h0000 : (sel < 10) ? 16'hFFFF : 16'($urandom);
				send_beat(alt, m, idle_pct, 1'b0, '0);
			end
		end

		start = 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (err_count == 0) begin
			$display("PASS gravity_by_altitude_interpolator_top");
		end else begin
			$display("FAIL gravity_by_altitude_interpolator_top");
		end
		$finish;
	end

endmodule
